// File: rtl/oba_pkg.sv
// ----------------------------------------------------------------------------
// oba_pkg
// Shared constants and types of the bundle aggregator: header words, codes
// and the result record that travels through the output queue.
// ----------------------------------------------------------------------------
`default_nettype none

package oba_pkg;

    localparam int unsigned BUNDLE_CAPACITY = 256;
    localparam int unsigned HEADER_BYTES    = 20;

    localparam logic [19:0] TTL_RESET = 20'd1000;
    localparam logic [19:0] AGE_MAX   = 20'hFFFFF;

    // "#bun", "dle\0", then the immediate timetag
    localparam logic [31:0] HDR_WORD1 = 32'h2362_756E;
    localparam logic [31:0] HDR_WORD2 = 32'h646C_6500;
    localparam logic [31:0] HDR_WORD3 = 32'h0000_0000;
    localparam logic [31:0] HDR_WORD4 = 32'h0000_0001;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic KIND_DATA  = 1'b0;
    localparam logic KIND_ERROR = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [31:0] word;
        logic [2:0]  bytes;
        logic        frame_last;
    } t_result;

endpackage

`default_nettype wire

// File: rtl/oba_ram.sv
// ----------------------------------------------------------------------------
// oba_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module oba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/oba_fifo.sv
// ----------------------------------------------------------------------------
// oba_fifo
// Two-entry result queue that carries flushed words and error results to the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module oba_fifo (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire oba_pkg::t_result i_data,
    input  wire logic             i_pop,
    output logic                  o_valid,
    output oba_pkg::t_result      o_data,
    output logic [1:0]            o_count
);

    import oba_pkg::*;

    t_result    r_q [2];
    logic       r_rd;
    logic       r_wr;
    logic [1:0] r_cnt;
    logic       pop_ok;

    assign pop_ok = i_pop && (r_cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (pop_ok) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(pop_ok);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr] <= i_data;
        end
    end

    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_q[r_rd];
    assign o_count = r_cnt;

endmodule

`default_nettype wire

// File: rtl/osc_bundle_aggregator.sv
// ----------------------------------------------------------------------------
// osc_bundle_aggregator
// Packs length-prefixed messages into a bundle store and streams finished
// bundles out as 32-bit words.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid/o_ready) carries one request per message byte or
//   per tick. Results leave on o_valid/i_ready: bundle words, or one error
//   result for a message that can never fit.
//   The store is four byte-lane RAMs, so one bundle word is read per cycle
//   while the output queue has room; the 20 header bytes are not stored
//   but generated while reading. A flush streams ceil(fill/4) words, at
//   most 64, one per cycle while the queue has room, through the single
//   read port; a flush in front of a message is followed by a write state
//   that puts the held byte into the new bundle.
//   Input is taken only while no flush is running.
//   A two-entry output queue decouples the receiver: while it stalls, the
//   reader stops issuing reads and the input is held off once the queue
//   is full. Reset empties the bundle, the queue and the age counter and
//   sets the TTL register to 1000 ticks; no clearing pass is needed.
//   Configuration (i_cfg_valid/o_cfg_ready) writes the TTL while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module osc_bundle_aggregator #(
    parameter int BUNDLE_CAPACITY = oba_pkg::BUNDLE_CAPACITY
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [19:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_cmd,
    input  wire logic [7:0]  i_msg_byte,
    input  wire logic [8:0]  i_msg_len,
    input  wire logic        i_msg_last,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic             o_out_kind,
    output logic [31:0]      o_out_word,
    output logic [2:0]       o_out_bytes,
    output logic             o_out_frame_last
);

    import oba_pkg::*;

    localparam int FW     = $clog2(BUNDLE_CAPACITY + 1);
    localparam int WDEPTH = (BUNDLE_CAPACITY + 3) / 4;
    localparam int AW     = $clog2(WDEPTH);
    localparam int WCW    = $clog2(WDEPTH + 1);
    localparam int LW     = ((FW > 9) ? FW : 9) + 1;

    localparam logic [LW-1:0] MAX_MSG = LW'(BUNDLE_CAPACITY - HEADER_BYTES);
    localparam logic [LW-1:0] CAP_L   = LW'(BUNDLE_CAPACITY);
    localparam logic [FW-1:0] CAP_F   = FW'(BUNDLE_CAPACITY);
    localparam logic [FW-1:0] HDR_F   = FW'(HEADER_BYTES);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FLUSH,
        S_WRITE
    } t_state;

    // control registers
    t_state         r_state, n_state;
    logic [FW-1:0]  r_fill, n_fill;
    logic [19:0]    r_age, n_age;
    logic           r_inmsg, n_inmsg;
    logic           r_drop, n_drop;
    logic           r_hold, n_hold;
    logic [19:0]    r_ttl, n_ttl;
    logic [WCW-1:0] r_widx, n_widx;
    logic           r_pend, n_pend;

    // payload registers
    logic [FW-1:0]  r_flen, n_flen;
    logic [WCW-1:0] r_nw, n_nw;
    logic [7:0]     r_hold_byte;
    logic           r_hold_last;
    logic [WCW-1:0] r_pidx;
    logic [2:0]     r_pcnt;
    logic           r_plast;

    logic           acc, first, drop_eff, pre_flush, open_new, wr, post_flush;
    logic           tick_flush, do_flush, hold_load, issue, pop;
    logic [LW-1:0]  len_x, free_x;
    logic [FW-1:0]  base_fill, new_fill, flush_len, rem, wr_pos;
    logic [19:0]    age_inc, base_age;
    logic [2:0]     iss_cnt;
    logic           iss_last;
    logic [1:0]     occ;
    logic [1:0]     fifo_count;
    logic           fifo_push;
    t_result        push_data, fifo_data;
    logic           ram_we;
    logic [7:0]     ram_wdata;
    logic [31:0]    rd_word, hdr_word;

    assign acc   = i_valid && o_ready;
    assign pop   = o_valid && i_ready;
    assign first = !r_inmsg;
    assign len_x = LW'(i_msg_len);
    assign free_x = CAP_L - LW'(r_fill);

    assign age_inc    = (r_age == AGE_MAX) ? r_age : r_age + 20'd1;
    assign drop_eff   = first ? (len_x > MAX_MSG) : r_drop;
    assign pre_flush  = first && !drop_eff && (len_x > free_x);
    assign open_new   = first && !drop_eff && (r_fill == '0);
    assign base_fill  = open_new ? HDR_F : r_fill;
    assign base_age   = open_new ? 20'd0 : r_age;
    assign wr         = !drop_eff && (base_fill < CAP_F);
    assign new_fill   = base_fill + FW'(wr);
    assign post_flush = i_msg_last && !drop_eff && (base_age > r_ttl);
    assign tick_flush = (!r_inmsg || r_drop) && (r_fill != '0) && (age_inc > r_ttl);

    // words in flight or queued, less the one leaving now
    assign occ   = fifo_count + 2'(r_pend) - 2'(pop);
    assign issue = (r_state == S_FLUSH) && (occ <= 2'd1);

    assign rem      = r_flen - FW'({r_widx, 2'b00});
    assign iss_cnt  = (rem >= FW'(4)) ? 3'd4 : 3'(rem);
    assign iss_last = (r_widx + WCW'(1) == r_nw);

    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_age     = r_age;
        n_inmsg   = r_inmsg;
        n_drop    = r_drop;
        n_hold    = r_hold;
        n_ttl     = r_ttl;
        n_widx    = r_widx;
        n_flen    = r_flen;
        n_nw      = r_nw;
        do_flush  = 1'b0;
        flush_len = r_fill;
        hold_load = 1'b0;
        ram_we    = 1'b0;
        wr_pos    = base_fill;
        ram_wdata = i_msg_byte;
        fifo_push = 1'b0;
        push_data = '{kind: KIND_ERROR, word: 32'd0, bytes: 3'd0, frame_last: 1'b0};

        if (i_cfg_valid && o_cfg_ready) begin
            n_ttl = i_cfg_data;
        end

        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    if (i_cmd == CMD_TICK) begin
                        if (tick_flush) begin
                            do_flush = 1'b1;
                        end else begin
                            n_age = age_inc;
                        end
                    end else if (drop_eff) begin
                        n_inmsg   = !i_msg_last;
                        n_drop    = !i_msg_last;
                        fifo_push = first;
                    end else if (pre_flush) begin
                        do_flush  = 1'b1;
                        hold_load = 1'b1;
                        n_hold    = 1'b1;
                        n_inmsg   = 1'b1;
                        n_drop    = 1'b0;
                    end else begin
                        ram_we  = wr;
                        n_fill  = new_fill;
                        n_age   = base_age;
                        n_drop  = 1'b0;
                        n_inmsg = !i_msg_last;
                        if (post_flush) begin
                            do_flush  = 1'b1;
                            flush_len = new_fill;
                        end
                    end
                end
            end
            S_FLUSH: begin
                if (issue) begin
                    n_widx = r_widx + WCW'(1);
                    if (iss_last) begin
                        n_state = r_hold ? S_WRITE : S_IDLE;
                    end
                end
            end
            S_WRITE: begin
                // held first byte opens the new bundle
                ram_we    = 1'b1;
                wr_pos    = HDR_F;
                ram_wdata = r_hold_byte;
                n_fill    = HDR_F + FW'(1);
                n_age     = 20'd0;
                n_hold    = 1'b0;
                if (r_hold_last) begin
                    n_inmsg = 1'b0;
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (do_flush) begin
            n_flen  = flush_len;
            n_nw    = WCW'(({1'b0, flush_len} + (FW+1)'(3)) >> 2);
            n_widx  = '0;
            n_fill  = '0;
            n_age   = 20'd0;
            n_state = S_FLUSH;
        end

        if (r_pend) begin
            fifo_push = 1'b1;
            push_data = '{kind: KIND_DATA, word: rd_word, bytes: r_pcnt,
                          frame_last: r_plast};
        end
    end

    assign n_pend = issue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_age   <= 20'd0;
            r_inmsg <= 1'b0;
            r_drop  <= 1'b0;
            r_hold  <= 1'b0;
            r_ttl   <= TTL_RESET;
            r_widx  <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_age   <= n_age;
            r_inmsg <= n_inmsg;
            r_drop  <= n_drop;
            r_hold  <= n_hold;
            r_ttl   <= n_ttl;
            r_widx  <= n_widx;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_flen <= n_flen;
        r_nw   <= n_nw;
        if (hold_load) begin
            r_hold_byte <= i_msg_byte;
            r_hold_last <= i_msg_last;
        end
        if (issue) begin
            r_pidx  <= r_widx;
            r_pcnt  <= iss_cnt;
            r_plast <= iss_last;
        end
    end

    // four byte lanes, lane 0 holds the most significant byte of a word
    logic [7:0] lane_rdata [4];

    for (genvar g = 0; g < 4; g++) begin : g_lane
        oba_ram #(
            .WIDTH (8),
            .DEPTH (WDEPTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (ram_we && (wr_pos[1:0] == 2'(g))),
            .i_waddr (AW'(wr_pos >> 2)),
            .i_wdata (ram_wdata),
            .i_raddr (AW'(r_widx)),
            .o_rdata (lane_rdata[g])
        );
    end

    always_comb begin
        case (r_pidx)
            WCW'(0): hdr_word = 32'(r_flen) - 32'd4;
            WCW'(1): hdr_word = HDR_WORD1;
            WCW'(2): hdr_word = HDR_WORD2;
            WCW'(3): hdr_word = HDR_WORD3;
            WCW'(4): hdr_word = HDR_WORD4;
            default: hdr_word = {lane_rdata[0], lane_rdata[1], lane_rdata[2], lane_rdata[3]};
        endcase
        rd_word = hdr_word;
        // bytes past the bundle end read as zero
        for (int k = 0; k < 4; k++) begin
            if (3'(k) >= r_pcnt) begin
                rd_word[31-8*k -: 8] = 8'd0;
            end
        end
    end

    oba_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fifo_push),
        .i_data  (push_data),
        .i_pop   (pop),
        .o_valid (o_valid),
        .o_data  (fifo_data),
        .o_count (fifo_count)
    );

    assign o_ready          = (r_state == S_IDLE) && !r_pend && (fifo_count != 2'd2);
    assign o_cfg_ready      = (r_state == S_IDLE);
    assign o_out_kind       = fifo_data.kind;
    assign o_out_word       = fifo_data.word;
    assign o_out_bytes      = fifo_data.bytes;
    assign o_out_frame_last = fifo_data.frame_last;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(fifo_push && (fifo_count == 2'd2) && !pop))
        else $error("result queue overflow");

    a_fill_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill == '0) || ((r_fill >= HDR_F) && (r_fill <= CAP_F)))
        else $error("fill length out of shape");

    a_flush_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLUSH) |-> (r_flen >= HDR_F))
        else $error("flush of a bundle shorter than its header");

    a_flush_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (issue && iss_last) |=> (r_state != S_FLUSH))
        else $error("reader kept running after the last word");

    a_push_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend) |-> !acc)
        else $error("input taken while a read word is arriving");

endmodule

`default_nettype wire
